/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off during reset.
`define RHP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("radiotap parser check failed");

// Same-cycle implication.
`define RHP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radiotap parser check failed");

// Next-cycle implication.
`define RHP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radiotap parser check failed");

`endif

/* hw/rtl/rhp_pkg.sv */
package rhp_pkg;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNKNOWN,
    ST_TRUNC,
    ST_OVERRUN,
    ST_SHORT
  } status_t;

  // Presence bits that are walked; anything from here up stops the walk.
  localparam logic [4:0] KnownFields = 5'd14;

  // Field ids that are kept
  localparam logic [3:0] F_TSFT    = 4'd0;
  localparam logic [3:0] F_FLAGS   = 4'd1;
  localparam logic [3:0] F_RATE    = 4'd2;
  localparam logic [3:0] F_CHANNEL = 4'd3;
  localparam logic [3:0] F_SIGNAL  = 4'd5;
  localparam logic [3:0] F_NOISE   = 4'd6;

  localparam logic [15:0] MinLength = 16'd8;

  // Frequency landmarks in MHz
  localparam logic [15:0] FreqCh14  = 16'd2484;
  localparam logic [15:0] Base2g    = 16'd2407;
  localparam logic [15:0] BaseHi2g  = 16'd2512;
  localparam logic [15:0] Base4g    = 16'd4000;
  localparam logic [15:0] Split49   = 16'd4900;
  localparam logic [15:0] SafetyLo  = 16'd4940;
  localparam logic [15:0] SafetyHi  = 16'd4990;
  localparam logic [15:0] Base5g    = 16'd5000;

  // Reciprocal of 5, exact with an 18-bit shift for 16-bit dividends
  localparam logic [33:0] RecipFive = 34'd52429;

  typedef struct packed {
    logic [7:0]  version;
    logic [15:0] length;
    logic [31:0] present;
    logic [63:0] tsft;
    logic [7:0]  flags;
    logic [6:0]  rate;
    logic [15:0] freq;
    logic [15:0] chan_flags;
    logic        chan_valid;
    logic [7:0]  signal;
    logic [7:0]  noise;
    status_t     status;
  } summary_t;

  // Byte size of each known field; ids above the table fall back to the first.
  function automatic logic [3:0] field_size(input logic [3:0] id);
    logic [3:0] s;
    unique case (id) inside
      4'd0, 4'd14, 4'd15:   s = 4'd8;
      4'd3:                 s = 4'd4;
      4'd4, [4'd7:4'd9]:    s = 4'd2;
      default:              s = 4'd1;
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/rhp_byte_if.sv */
interface rhp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

/* hw/rtl/rhp_result_if.sv */
interface rhp_result_if;
  import rhp_pkg::*;

  logic               valid;
  logic               ready;
  logic [7:0]         header_version;
  logic [15:0]        header_length;
  logic [31:0]        present_word;
  logic [63:0]        mac_timestamp;
  logic [7:0]         radio_flags;
  logic [6:0]         rate_half_mbps;
  logic [15:0]        channel_freq;
  logic [15:0]        channel_type;
  logic signed [14:0] channel_number;
  logic signed [7:0]  signal_dbm;
  logic signed [7:0]  noise_dbm;
  status_t            status;

  modport source (
    output valid, header_version, header_length, present_word, mac_timestamp,
           radio_flags, rate_half_mbps, channel_freq, channel_type,
           channel_number, signal_dbm, noise_dbm, status,
    input  ready
  );
  modport sink (
    input  valid, header_version, header_length, present_word, mac_timestamp,
           radio_flags, rate_half_mbps, channel_freq, channel_type,
           channel_number, signal_dbm, noise_dbm, status,
    output ready
  );
endinterface

/* hw/rtl/radiotap_header_parser_top.sv */
// Radiotap header parser.
// frame: capture bytes in order, one request per byte; first_byte restarts
//   the parse, last_byte marks the end of the frame. Bytes after the header
//   walk has ended are taken and dropped until the next first_byte.
// summary: one request per frame with the header fields, the derived IEEE
//   channel number and a status code (ok, unknown field, truncated, overrun,
//   short length).
// Throughput: one byte per cycle while frame.ready is high; each byte updates
//   the parse registers in the cycle it is taken, with the presence-bit
//   priority pick and the field bound compare as the longest path.
// Result path: the byte that ends the walk loads the parse register stage,
//   and the channel stage registers the summary from it; the divide-by-5
//   reciprocal multiply sets that stage.
// Stall: a finished summary waits at the output while parsing goes on; a
//   second one waits in the stage behind it, and only then is frame.ready
//   dropped.
// Reset (rst, synchronous): parse state clears, both result stages empty,
//   and the block waits for a byte with first_byte set.
`include "assert_macros.svh"

module radiotap_header_parser_top (
  input  logic                clk,
  input  logic                rst,
  rhp_byte_if.sink            frame,
  rhp_result_if.source        summary
);
  import rhp_pkg::*;

  typedef enum logic [2:0] {
    CH_NONE,
    CH_FOURTEEN,
    CH_LOW,
    CH_MID,
    CH_SAFE,
    CH_OFF4000,
    CH_OFF5000
  } ch_mode_t;

  // parse state
  logic [15:0] byte_index, byte_index_next;
  logic [15:0] length_reg, length_reg_next;
  logic [7:0]  version_reg, version_reg_next;
  logic [31:0] present_reg, present_reg_next;
  logic [31:0] pending_bits, pending_bits_next;
  logic [3:0]  field_id, field_id_next;
  logic [3:0]  field_byte_count, field_byte_count_next;
  logic [63:0] field_shift, field_shift_next;
  logic [63:0] tsft_reg, tsft_reg_next;
  logic [7:0]  flags_reg, flags_reg_next;
  logic [6:0]  rate_reg, rate_reg_next;
  logic [15:0] chan_freq_reg, chan_freq_reg_next;
  logic [15:0] chan_flags_reg, chan_flags_reg_next;
  logic        chan_valid, chan_valid_next;
  logic [7:0]  signal_reg, signal_reg_next;
  logic [7:0]  noise_reg, noise_reg_next;
  logic        header_done, header_done_next;

  logic        accept;
  logic        done;
  status_t     status_res;
  logic [15:0] idx;
  logic [3:0]  cur_size;
  logic [3:0]  count_inc;
  logic        walk_go;
  logic [31:0] walk_src;
  logic [4:0]  walk_bit;
  logic [3:0]  walk_size;

  // result stages
  logic        s1_valid;
  summary_t    s1;
  logic        out_valid;
  summary_t    out_q;
  logic signed [14:0] out_chan;
  logic        out_free;
  logic        s1_free;

  // channel stage
  ch_mode_t    ch_mode;
  logic        ch_safety;
  logic [15:0] ch_base;
  logic signed [17:0] ch_num;
  logic [16:0] ch_mag;
  logic [33:0] ch_prod;
  logic [15:0] ch_q5;
  logic [15:0] ch_q;
  logic signed [15:0] ch_signed;
  logic [5:0]  ch_d;
  logic [11:0] ch_d13;
  logic [5:0]  ch_rem;
  logic signed [15:0] ch_val;

  function automatic logic [4:0] lowest_bit(input logic [31:0] v);
    logic [4:0] r;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) r = 5'(i);
    end
    return r;
  endfunction

  assign out_free    = !out_valid || summary.ready;
  assign s1_free     = !s1_valid || out_free;
  assign frame.ready = s1_free;
  assign accept      = frame.valid && frame.ready;

  always_comb begin
    byte_index_next       = byte_index;
    length_reg_next       = length_reg;
    version_reg_next      = version_reg;
    present_reg_next      = present_reg;
    pending_bits_next     = pending_bits;
    field_id_next         = field_id;
    field_byte_count_next = field_byte_count;
    field_shift_next      = field_shift;
    tsft_reg_next         = tsft_reg;
    flags_reg_next        = flags_reg;
    rate_reg_next         = rate_reg;
    chan_freq_reg_next    = chan_freq_reg;
    chan_flags_reg_next   = chan_flags_reg;
    chan_valid_next       = chan_valid;
    signal_reg_next       = signal_reg;
    noise_reg_next        = noise_reg;
    header_done_next      = header_done;
    done       = 1'b0;
    status_res = ST_OK;
    idx        = '0;
    cur_size   = '0;
    count_inc  = '0;
    walk_go    = 1'b0;
    walk_src   = '0;
    walk_bit   = '0;
    walk_size  = '0;

    if (accept && frame.first_byte) begin
      byte_index_next       = '0;
      length_reg_next       = '0;
      version_reg_next      = '0;
      present_reg_next      = '0;
      pending_bits_next     = '0;
      field_id_next         = '0;
      field_byte_count_next = '0;
      field_shift_next      = '0;
      tsft_reg_next         = '0;
      flags_reg_next        = '0;
      rate_reg_next         = '0;
      chan_freq_reg_next    = '0;
      chan_flags_reg_next   = '0;
      chan_valid_next       = 1'b0;
      signal_reg_next       = '0;
      noise_reg_next        = '0;
      header_done_next      = 1'b0;
    end

    if (accept && (frame.first_byte || !header_done)) begin
      idx             = byte_index_next;
      byte_index_next = idx + 16'd1;

      if (idx < 16'd8) begin
        case (idx[2:0])
          3'd0: version_reg_next = frame.data_byte;
          3'd1: ;
          3'd2: length_reg_next = {8'h00, frame.data_byte};
          3'd3: length_reg_next = {frame.data_byte, length_reg_next[7:0]};
          default: begin
            present_reg_next = present_reg_next |
              (32'(frame.data_byte) << {idx[1:0], 3'b000});
          end
        endcase
        if (idx[2:0] == 3'd7) begin
          if (length_reg_next < MinLength) begin
            status_res = ST_SHORT;
            done       = 1'b1;
          end else begin
            pending_bits_next = present_reg_next;
            walk_src          = present_reg_next;
            walk_go           = 1'b1;
          end
        end
      end else begin
        cur_size  = field_size(field_id_next);
        count_inc = field_byte_count_next + 4'd1;
        field_shift_next = field_shift_next |
          (64'(frame.data_byte) << {field_byte_count_next[2:0], 3'b000});
        field_byte_count_next = count_inc;
        if (count_inc >= cur_size) begin
          case (field_id_next)
            F_TSFT:  tsft_reg_next  = field_shift_next;
            F_FLAGS: flags_reg_next = field_shift_next[7:0];
            F_RATE:  rate_reg_next  = field_shift_next[6:0];
            F_CHANNEL: begin
              chan_freq_reg_next  = field_shift_next[15:0];
              chan_flags_reg_next = field_shift_next[31:16];
              chan_valid_next     = 1'b1;
            end
            F_SIGNAL: signal_reg_next = field_shift_next[7:0];
            F_NOISE:  noise_reg_next  = field_shift_next[7:0];
            default: ;
          endcase
          pending_bits_next = pending_bits_next & ~(32'd1 << field_id_next);
          walk_src          = pending_bits_next;
          walk_go           = 1'b1;
        end
      end

      // pick the next present field, or end the walk
      if (walk_go) begin
        walk_bit  = lowest_bit(walk_src);
        walk_size = field_size(walk_bit[3:0]);
        if (walk_src == '0) begin
          status_res = ST_OK;
          done       = 1'b1;
        end else if (walk_bit >= KnownFields) begin
          status_res = ST_UNKNOWN;
          done       = 1'b1;
        end else if (({1'b0, byte_index_next} + 17'(walk_size)) >
                     {1'b0, length_reg_next}) begin
          status_res = ST_OVERRUN;
          done       = 1'b1;
        end else begin
          field_id_next         = walk_bit[3:0];
          field_byte_count_next = '0;
          field_shift_next      = '0;
        end
      end

      if (!done && frame.last_byte) begin
        status_res = ST_TRUNC;
        done       = 1'b1;
      end
      if (done) header_done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index       <= '0;
      length_reg       <= '0;
      version_reg      <= '0;
      present_reg      <= '0;
      pending_bits     <= '0;
      field_id         <= '0;
      field_byte_count <= '0;
      field_shift      <= '0;
      tsft_reg         <= '0;
      flags_reg        <= '0;
      rate_reg         <= '0;
      chan_freq_reg    <= '0;
      chan_flags_reg   <= '0;
      chan_valid       <= 1'b0;
      signal_reg       <= '0;
      noise_reg        <= '0;
      header_done      <= 1'b1;
    end else begin
      byte_index       <= byte_index_next;
      length_reg       <= length_reg_next;
      version_reg      <= version_reg_next;
      present_reg      <= present_reg_next;
      pending_bits     <= pending_bits_next;
      field_id         <= field_id_next;
      field_byte_count <= field_byte_count_next;
      field_shift      <= field_shift_next;
      tsft_reg         <= tsft_reg_next;
      flags_reg        <= flags_reg_next;
      rate_reg         <= rate_reg_next;
      chan_freq_reg    <= chan_freq_reg_next;
      chan_flags_reg   <= chan_flags_reg_next;
      chan_valid       <= chan_valid_next;
      signal_reg       <= signal_reg_next;
      noise_reg        <= noise_reg_next;
      header_done      <= header_done_next;
    end
  end

  // parse result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= done;
    end
    if (done) begin
      s1.version    <= version_reg_next;
      s1.length     <= length_reg_next;
      s1.present    <= present_reg_next;
      s1.tsft       <= tsft_reg_next;
      s1.flags      <= flags_reg_next;
      s1.rate       <= rate_reg_next;
      s1.freq       <= chan_freq_reg_next;
      s1.chan_flags <= chan_flags_reg_next;
      s1.chan_valid <= chan_valid_next;
      s1.signal     <= signal_reg_next;
      s1.noise      <= noise_reg_next;
      s1.status     <= status_res;
    end
  end

  // band rules for the channel number
  always_comb begin
    ch_safety = (s1.freq > SafetyLo) && (s1.freq < SafetyHi);
    if (!s1.chan_valid) begin
      ch_mode = CH_NONE;
    end else if (s1.chan_flags[7]) begin
      if (s1.freq == FreqCh14)     ch_mode = CH_FOURTEEN;
      else if (s1.freq < FreqCh14) ch_mode = CH_LOW;
      else                         ch_mode = CH_MID;
    end else if (s1.chan_flags[8]) begin
      if (ch_safety)               ch_mode = CH_SAFE;
      else if (s1.freq <= Base5g)  ch_mode = CH_OFF4000;
      else                         ch_mode = CH_OFF5000;
    end else if (s1.freq == FreqCh14) begin
      ch_mode = CH_FOURTEEN;
    end else if (s1.freq < FreqCh14) begin
      ch_mode = CH_LOW;
    end else if (s1.freq < Base5g) begin
      if (ch_safety)               ch_mode = CH_SAFE;
      else if (s1.freq > Split49)  ch_mode = CH_OFF4000;
      else                         ch_mode = CH_MID;
    end else begin
      ch_mode = CH_OFF5000;
    end

    case (ch_mode)
      CH_LOW:     ch_base = Base2g;
      CH_MID:     ch_base = BaseHi2g;
      CH_OFF4000: ch_base = Base4g;
      CH_OFF5000: ch_base = Base5g;
      default:    ch_base = '0;
    endcase

    // truncating signed divide: divide the magnitude, restore the sign
    ch_num    = $signed({2'b00, s1.freq}) - $signed({2'b00, ch_base});
    ch_mag    = ch_num[17] ? 17'(-ch_num) : ch_num[16:0];
    ch_prod   = 34'(ch_mag) * RecipFive;
    ch_q5     = ch_prod[33:18];
    ch_q      = (ch_mode == CH_MID) ? {2'b00, ch_q5[15:2]} : ch_q5;
    ch_signed = ch_num[17] ? -$signed(ch_q) : $signed(ch_q);

    // public safety band: twice the offset from 4940, plus one when f mod 5 is 2
    ch_d   = 6'(s1.freq - SafetyLo);
    ch_d13 = 12'(ch_d) * 12'd13;
    ch_rem = ch_d - 6'({ch_d13[11:6], 2'b00}) - ch_d13[11:6];

    case (ch_mode)
      CH_NONE:     ch_val = '0;
      CH_FOURTEEN: ch_val = 16'sd14;
      CH_MID:      ch_val = ch_signed + 16'sd15;
      CH_SAFE:     ch_val = $signed({9'b0, ch_d, 1'b0}) +
                            $signed({15'b0, (ch_rem == 6'd2)});
      default:     ch_val = ch_signed;
    endcase
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
    if (out_free && s1_valid) begin
      out_q    <= s1;
      out_chan <= 15'(ch_val);
    end
  end

  assign summary.valid          = out_valid;
  assign summary.header_version = out_q.version;
  assign summary.header_length  = out_q.length;
  assign summary.present_word   = out_q.present;
  assign summary.mac_timestamp  = out_q.tsft;
  assign summary.radio_flags    = out_q.flags;
  assign summary.rate_half_mbps = out_q.rate;
  assign summary.channel_freq   = out_q.freq;
  assign summary.channel_type   = out_q.chan_flags;
  assign summary.channel_number = out_chan;
  assign summary.signal_dbm     = $signed(out_q.signal);
  assign summary.noise_dbm      = $signed(out_q.noise);
  assign summary.status         = out_q.status;

  `RHP_ASSERT_NEXT(a_done_sets_idle, clk, rst, done, header_done)
  `RHP_ASSERT_IMPL(a_s1_from_byte, clk, rst, $rose(s1_valid), $past(accept))
  `RHP_ASSERT_IMPL(a_field_id_known, clk, rst,
    (!header_done && (byte_index >= MinLength)), ({1'b0, field_id} < KnownFields))
  `RHP_ASSERT_IMPL(a_status_range, clk, rst, summary.valid, summary.status <= ST_SHORT)

endmodule
